### design/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types, constants and sequence arithmetic for the selective repeat
// sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int SEQ_SPACE    = 8;
    localparam int WINDOW       = 3;
    localparam int PAYLOAD_BITS = 32;
    localparam int SEQ_BITS     = $clog2(SEQ_SPACE);
    localparam int MEM_BITS     = PAYLOAD_BITS + 1;   // ack mark above payload

    localparam logic [SEQ_BITS-1:0] SEQ_RESET = SEQ_BITS'(1 % SEQ_SPACE);

    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_EXPIRE = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    ack_ok;
        logic [SEQ_BITS-1:0]     ack_number;
        logic [SEQ_BITS-1:0]     expired_number;
    } t_item;

    typedef struct packed {
        logic                    accepted;
        logic                    window_full;
        logic                    tx_valid;
        logic [SEQ_BITS-1:0]     tx_seq;
        logic [PAYLOAD_BITS-1:0] tx_payload;
        logic                    timer_start;
        logic                    timer_stop;
        logic [SEQ_BITS-1:0]     timer_seq;
        logic [SEQ_BITS-1:0]     window_base;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SLIDE
    } t_state;

    function automatic logic [SEQ_BITS-1:0] seq_inc(input logic [SEQ_BITS-1:0] s);
        logic [SEQ_BITS-1:0] r;
        if (s == SEQ_BITS'(SEQ_SPACE - 1)) begin
            r = '0;
        end else begin
            r = s + SEQ_BITS'(1);
        end
        return r;
    endfunction

    // (a - b) mod SEQ_SPACE
    function automatic logic [SEQ_BITS-1:0] seq_dist(input logic [SEQ_BITS-1:0] a,
                                                      input logic [SEQ_BITS-1:0] b);
        logic [SEQ_BITS:0] d;
        if (a >= b) begin
            d = {1'b0, a} - {1'b0, b};
        end else begin
            d = {1'b0, a} + (SEQ_BITS+1)'(SEQ_SPACE) - {1'b0, b};
        end
        return d[SEQ_BITS-1:0];
    endfunction

    function automatic logic is_full(input logic [SEQ_BITS-1:0] next_s,
                                     input logic [SEQ_BITS-1:0] base_s);
        return int'(seq_dist(next_s, base_s)) >= WINDOW;
    endfunction

endpackage

### design/srsw_ram.sv
// ----------------------------------------------------------------------------
// srsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/selective_repeat_sender_window.sv
// An accepted item passes the EXEC state and its result strobes on o_done
// from a register. An ack of the window base adds the SLIDE state, which steps
// past each acked entry. No new item is taken while busy; the slide walks the
// ack marks through the single read port of the packet RAM.
// Reset (i_rst_n low, synchronous): base = next = 1, window not full, idle.
// Results cannot be stalled; the receiver takes each o_done cycle as it comes.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Selective repeat sender window: stores outstanding packets with their ack
// marks in one RAM, handles sends, acks with window slide, and resends.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  srsw_pkg::t_item   i_item,
    output logic              o_done,
    output srsw_pkg::t_result o_result
);

    import srsw_pkg::*;

    t_state              r_state, n_state;
    logic [SEQ_BITS-1:0] r_start, n_start;
    logic [SEQ_BITS-1:0] r_next, n_next;
    logic                r_full, n_full;
    logic                r_done, n_done;
    t_item               r_item, n_item;
    t_result             r_res, n_res;

    logic                mem_we;
    logic [SEQ_BITS-1:0] mem_waddr;
    logic [MEM_BITS-1:0] mem_wdata;
    logic [SEQ_BITS-1:0] mem_raddr;
    logic [MEM_BITS-1:0] mem_rdata;
    logic                rd_mark;
    logic [PAYLOAD_BITS-1:0] rd_payload;

    srsw_ram #(
        .WIDTH (MEM_BITS),
        .DEPTH (SEQ_SPACE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_mark    = mem_rdata[PAYLOAD_BITS];
    assign rd_payload = mem_rdata[PAYLOAD_BITS-1:0];

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= SEQ_RESET;
            r_next  <= SEQ_RESET;
            r_full  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_next  <= n_next;
            r_full  <= n_full;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_start   = r_start;
        n_next    = r_next;
        n_full    = r_full;
        n_done    = 1'b0;
        n_item    = r_item;
        n_res     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_start;
        mem_wdata = '0;
        mem_raddr = r_start;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_item    = i_item;
                    n_state   = ST_EXEC;
                    mem_raddr = (i_item.kind == KIND_ACK) ? i_item.ack_number
                                                          : i_item.expired_number;
                end
            end

            ST_EXEC: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                unique case (r_item.kind)
                    KIND_SEND: begin
                        if (!r_full) begin
                            mem_we            = 1'b1;
                            mem_waddr         = r_next;
                            mem_wdata         = {1'b0, r_item.payload};
                            n_res.accepted    = 1'b1;
                            n_res.tx_valid    = 1'b1;
                            n_res.tx_seq      = r_next;
                            n_res.tx_payload  = r_item.payload;
                            n_res.timer_start = 1'b1;
                            n_res.timer_seq   = r_next;
                            n_next            = seq_inc(r_next);
                            n_full            = is_full(seq_inc(r_next), r_start);
                        end
                    end
                    KIND_ACK: begin
                        if (r_item.ack_ok) begin
                            n_res.timer_stop = 1'b1;
                            n_res.timer_seq  = r_item.ack_number;
                            if (seq_dist(r_item.ack_number, r_start) <
                                seq_dist(r_next, r_start)) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_item.ack_number;
                                if (r_item.ack_number == r_start) begin
                                    // base is passed at once; its mark is left clear
                                    mem_wdata = {1'b0, rd_payload};
                                    n_start   = seq_inc(r_start);
                                    mem_raddr = seq_inc(r_start);
                                    n_state   = ST_SLIDE;
                                    n_done    = 1'b0;
                                end else begin
                                    mem_wdata = {1'b1, rd_payload};
                                end
                            end
                        end
                    end
                    KIND_EXPIRE: begin
                        n_res.tx_valid    = 1'b1;
                        n_res.tx_seq      = r_item.expired_number;
                        n_res.tx_payload  = rd_payload;
                        n_res.timer_start = 1'b1;
                        n_res.timer_seq   = r_item.expired_number;
                    end
                    default: begin
                    end
                endcase
            end

            ST_SLIDE: begin
                // read data holds the entry at r_start
                if (r_start == r_next || !rd_mark) begin
                    n_full           = is_full(r_next, r_start);
                    n_res.timer_stop = 1'b1;
                    n_res.timer_seq  = r_item.ack_number;
                    n_done           = 1'b1;
                    n_state          = ST_IDLE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_start;
                    mem_wdata = {1'b0, rd_payload};
                    n_start   = seq_inc(r_start);
                    mem_raddr = seq_inc(r_start);
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_res.window_full = n_full;
        n_res.window_base = n_start;
    end

    // results only leave as the block returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed while busy");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_full == is_full(r_next, r_start)))
        else $error("full flag out of step with window occupancy");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(seq_dist(r_next, r_start)) <= WINDOW)
        else $error("window holds more than WINDOW packets");

    a_send_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.kind == KIND_SEND && !r_full)
            |=> ##1 (o_done && o_result.accepted))
        else $error("send with room not taken");

endmodule
